// ===== rtl/core/activation_function_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// activation_function_unit_top_assert.svh
// Assertion macros used by the activation function unit checker.
// ----------------------------------------------------------------------------
`ifndef ACTIVATION_FUNCTION_UNIT_TOP_ASSERT_SVH
`define ACTIVATION_FUNCTION_UNIT_TOP_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define AFU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand on the standard clock and reset names.
`define AFU_ASSERT(lbl, prop, msg) `AFU_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/afu_pkg.sv =====
// ----------------------------------------------------------------------------
// afu_pkg
// Types and constants of the activation function unit.
// ----------------------------------------------------------------------------
`default_nettype none

package afu_pkg;

    localparam int XW    = 16;      // Q4.11 argument and result
    localparam int OPW   = 3;
    localparam int AW    = 16;      // |x|, up to 32768
    localparam int MW    = 36;      // exp argument in Q.30
    localparam int QW    = 6;       // ln2 quotient
    localparam int NTERM = 14;      // exp series terms
    localparam int NLN   = 12;      // atanh series terms
    localparam int QBITS = 31;      // divider quotient bits
    localparam int MGW   = 61;      // pre-rounding magnitude

    localparam logic [30:0] ONE_W = 31'h4000_0000;
    localparam logic [29:0] LN2   = 30'd744261118;
    localparam logic [10:0] RQ    = 11'((64'd1 << 40) / 64'(LN2));

    typedef enum logic [OPW-1:0] {
        OP_SIG    = 3'd0,
        OP_DSIG   = 3'd1,
        OP_TANH   = 3'd2,
        OP_DTANH  = 3'd3,
        OP_SOFTP  = 3'd4,
        OP_DSOFTP = 3'd5,
        OP_SWISH  = 3'd6,
        OP_DSWISH = 3'd7
    } t_op;

    typedef struct packed {
        t_op           op;
        logic          neg;
        logic [AW-1:0] a;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [30:0] s;
        logic [30:0] t;
    } t_post;

endpackage

`default_nettype wire

// ===== rtl/core/afu_exp.sv =====
// ----------------------------------------------------------------------------
// afu_exp
// Two-lane pipelined exp(-m): ln2 range reduction, 14-term Taylor series
// (multiply, reciprocal divide, correct per term), final binary shift.
// ----------------------------------------------------------------------------
`default_nettype none

module afu_exp
    import afu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    output logic             o_vld,
    output t_side            o_side,
    output logic [1:0][30:0] o_e
);

    localparam int ExpLat = 3 + 3 * NTERM + 1;

    logic [ExpLat-1:0] r_vld;
    t_side             r_side [ExpLat];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ExpLat-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < ExpLat; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    for (genvar gl = 0; gl < 2; gl++) begin : g_lane
        logic [MW-1:0] w_m;
        logic [47:0]   w_qp;
        logic [MW-1:0] w_qm;
        logic [MW-1:0] r_m;
        logic [QW-1:0] r_qe;
        logic [QW-1:0] r_q2;
        logic [30:0]   r_rr;
        logic [29:0]   r_r0;
        logic [QW-1:0] r_q0;
        logic [30:0]   c_term [NTERM+1];
        logic [30:0]   c_sum  [NTERM+1];
        logic [29:0]   c_r    [NTERM+1];
        logic [QW-1:0] c_q    [NTERM+1];
        logic [30:0]   r_e;

        assign w_m  = MW'(i_side.a) << (19 + gl);
        assign w_qp = 48'(w_m) * 48'(RQ);
        assign w_qm = MW'(r_qe) * MW'(LN2);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m  <= w_m;
                r_qe <= w_qp[45:40];
                r_rr <= 31'(r_m - w_qm);
                r_q2 <= r_qe;
                if (r_rr >= {1'b0, LN2}) begin
                    r_r0 <= 30'(r_rr - {1'b0, LN2});
                    r_q0 <= r_q2 + QW'(1);
                end else begin
                    r_r0 <= r_rr[29:0];
                    r_q0 <= r_q2;
                end
            end
        end

        assign c_term[0] = ONE_W;
        assign c_sum[0]  = ONE_W;
        assign c_r[0]    = r_r0;
        assign c_q[0]    = r_q0;

        for (genvar gk = 1; gk <= NTERM; gk++) begin : g_term
            localparam int          K   = gk;
            localparam logic [32:0] RK  = 33'((64'd1 << 32) / K);
            localparam bit          Odd = (K % 2) == 1;

            logic [60:0]   w_prod;
            logic [62:0]   w_rp;
            logic [33:0]   w_ek;
            logic [33:0]   w_rem;
            logic [29:0]   w_term;
            logic [29:0]   r_pa, r_ra, r_pb, r_rb, r_estb, r_rc;
            logic [30:0]   r_suma, r_sumb, r_sumc, r_termc;
            logic [QW-1:0] r_qa, r_qb, r_qc;

            assign w_prod = 61'(c_term[gk-1]) * 61'(c_r[gk-1]);
            assign w_rp   = 63'(r_pa) * 63'(RK);
            assign w_ek   = 34'(r_estb) * 34'(K);
            assign w_rem  = 34'(r_pb) - w_ek;
            assign w_term = r_estb + 30'(w_rem >= 34'(K));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa    <= w_prod[59:30];
                    r_ra    <= c_r[gk-1];
                    r_qa    <= c_q[gk-1];
                    r_suma  <= c_sum[gk-1];
                    r_pb    <= r_pa;
                    r_estb  <= w_rp[61:32];
                    r_rb    <= r_ra;
                    r_qb    <= r_qa;
                    r_sumb  <= r_suma;
                    r_termc <= {1'b0, w_term};
                    r_sumc  <= Odd ? r_sumb - {1'b0, w_term} : r_sumb + {1'b0, w_term};
                    r_rc    <= r_rb;
                    r_qc    <= r_qb;
                end
            end

            assign c_term[gk] = r_termc;
            assign c_sum[gk]  = r_sumc;
            assign c_r[gk]    = r_rc;
            assign c_q[gk]    = r_qc;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e <= (c_q[NTERM] == {QW{1'b1}}) ? '0 : c_sum[NTERM] >> c_q[NTERM];
            end
        end

        assign o_e[gl] = r_e;
    end

    assign o_vld  = r_vld[ExpLat-1];
    assign o_side = r_side[ExpLat-1];

endmodule

`default_nettype wire

// ===== rtl/core/afu_div.sv =====
// ----------------------------------------------------------------------------
// afu_div
// Three-lane restoring divider, one quotient bit per stage: sigmoid,
// |tanh| and the atanh argument z.
// ----------------------------------------------------------------------------
`default_nettype none

module afu_div
    import afu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [1:0][30:0] i_e,
    output logic             o_vld,
    output t_post            o_post,
    output logic [30:0]      o_z
);

    localparam int DivLat = 1 + QBITS;

    logic [DivLat-1:0] r_vld;
    t_side             r_side [DivLat];
    logic [61:0]       w_n    [3];
    logic [31:0]       w_d    [3];
    logic [QBITS-1:0]  w_quo  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivLat-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < DivLat; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_comb begin
        w_d[0] = 32'(ONE_W) + 32'(i_e[0]);
        w_n[0] = (62'(1) << 60) + 62'(w_d[0] >> 1);
        w_d[1] = 32'(ONE_W) + 32'(i_e[1]);
        w_n[1] = (62'(ONE_W - i_e[1]) << 30) + 62'(w_d[1] >> 1);
        w_d[2] = (32'(1) << 31) + 32'(i_e[0]);
        w_n[2] = (62'(i_e[0]) << 30) + 62'(w_d[2] >> 1);
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
        logic [61:0]      r_rem [QBITS];
        logic [31:0]      r_dv  [QBITS];
        logic [QBITS-1:0] r_q   [QBITS+1];
        logic [61:0]      w_ds  [QBITS];
        logic [QBITS-1:0] w_ge;

        always_comb begin
            for (int j = 0; j < QBITS; j++) begin
                w_ds[j] = 62'(r_dv[j]) << (QBITS - 1 - j);
                w_ge[j] = r_rem[j] >= w_ds[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0] <= w_n[gl];
                r_dv[0]  <= w_d[gl];
                r_q[0]   <= '0;
                for (int j = 0; j < QBITS - 1; j++) begin
                    r_rem[j+1] <= w_ge[j] ? r_rem[j] - w_ds[j] : r_rem[j];
                    r_dv[j+1]  <= r_dv[j];
                end
                for (int j = 0; j < QBITS; j++) begin
                    r_q[j+1] <= r_q[j] | (QBITS'(w_ge[j]) << (QBITS - 1 - j));
                end
            end
        end

        assign w_quo[gl] = r_q[QBITS];
    end

    assign o_vld       = r_vld[DivLat-1];
    assign o_post.side = r_side[DivLat-1];
    assign o_post.s    = r_side[DivLat-1].neg ? ONE_W - w_quo[0] : w_quo[0];
    assign o_post.t    = w_quo[1];
    assign o_z         = w_quo[2];

endmodule

`default_nettype wire

// ===== rtl/core/afu_ln.sv =====
// ----------------------------------------------------------------------------
// afu_ln
// ln(1+E) as 2*atanh(z): z squared, then 12 series terms of
// multiply, reciprocal divide by 2k+1, correct and accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module afu_ln
    import afu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_post       i_post,
    input  logic [30:0] i_z,
    output logic        o_vld,
    output t_post       o_post,
    output logic [31:0] o_ln
);

    localparam int LnLat = 1 + 3 * NLN;

    logic [LnLat-1:0] r_vld;
    t_post            r_post [LnLat];
    logic [61:0]      w_zz;
    logic [29:0]      r_z2;
    logic [30:0]      r_z;
    logic [29:0]      c_z2   [NLN+1];
    logic [30:0]      c_term [NLN+1];
    logic [30:0]      c_sum  [NLN+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LnLat-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_post[0] <= i_post;
            for (int i = 1; i < LnLat; i++) begin
                r_post[i] <= r_post[i-1];
            end
        end
    end

    assign w_zz = 62'(i_z) * 62'(i_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z2 <= w_zz[59:30];
            r_z  <= i_z;
        end
    end

    assign c_z2[0]   = r_z2;
    assign c_term[0] = r_z;
    assign c_sum[0]  = r_z;

    for (genvar gk = 1; gk <= NLN; gk++) begin : g_term
        localparam int          K  = 2 * gk + 1;
        localparam logic [31:0] RK = 32'((64'd1 << 32) / K);

        logic [60:0] w_prod;
        logic [62:0] w_rp;
        logic [35:0] w_ek;
        logic [35:0] w_rem;
        logic [30:0] w_q;
        logic [29:0] r_z2a, r_z2b, r_z2c;
        logic [30:0] r_ta, r_tb, r_tc, r_estb;
        logic [30:0] r_suma, r_sumb, r_sumc;

        assign w_prod = 61'(c_term[gk-1]) * 61'(c_z2[gk-1]);
        assign w_rp   = 63'(r_ta) * 63'(RK);
        assign w_ek   = 36'(r_estb) * 36'(K);
        assign w_rem  = 36'(r_tb) - w_ek;
        assign w_q    = r_estb + 31'(w_rem >= 36'(K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ta   <= w_prod[60:30];
                r_z2a  <= c_z2[gk-1];
                r_suma <= c_sum[gk-1];
                r_tb   <= r_ta;
                r_estb <= w_rp[62:32];
                r_z2b  <= r_z2a;
                r_sumb <= r_suma;
                r_tc   <= r_tb;
                r_z2c  <= r_z2b;
                r_sumc <= r_sumb + w_q;
            end
        end

        assign c_z2[gk]   = r_z2c;
        assign c_term[gk] = r_tc;
        assign c_sum[gk]  = r_sumc;
    end

    assign o_vld  = r_vld[LnLat-1];
    assign o_post = r_post[LnLat-1];
    assign o_ln   = {c_sum[NLN], 1'b0};

endmodule

`default_nettype wire

// ===== rtl/core/afu_out.sv =====
// ----------------------------------------------------------------------------
// afu_out
// Output stages: derivative and swish products, per-op selection,
// swish derivative sum, round half away from zero, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module afu_out
    import afu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_post         i_post,
    input  logic [31:0]   i_ln,
    output logic          o_vld,
    output logic [XW-1:0] o_y,
    output logic          o_sat
);

    typedef enum logic [1:0] {
        FR_30,
        FR_41,
        FR_60
    } t_frac;

    logic [4:0] r_vld;

    // stage 1
    logic [30:0]    w_oms;
    logic [61:0]    w_ds;
    logic [61:0]    w_tsq;
    logic [46:0]    w_ax;
    logic [35:0]    w_spv;
    t_post          r1_post;
    logic [MGW-1:0] r1_ds;
    logic [MGW-1:0] r1_tt;
    logic [46:0]    r1_ax;
    logic [35:0]    r1_spv;

    // stage 2
    logic [MGW-1:0] w2_mag;
    logic           w2_sgn;
    t_frac          w2_fr;
    logic [MGW-1:0] w2_pr;
    t_side          r2_side;
    logic [30:0]    r2_s;
    logic [28:0]    r2_p;
    logic [MGW-1:0] r2_mag;
    logic           r2_sgn;
    t_frac          r2_fr;

    // stage 3
    t_side          r3_side;
    logic [30:0]    r3_s;
    logic [44:0]    r3_xp;
    logic [MGW-1:0] r3_mag;
    logic           r3_sgn;
    t_frac          r3_fr;

    // stage 4
    logic [45:0]    w4_sh;
    logic [45:0]    w4_xp;
    logic [MGW-1:0] w4_mag;
    logic           w4_sgn;
    logic [MGW-1:0] r4_mag;
    logic           r4_sgn;
    t_frac          r4_fr;

    // stage 5
    logic [61:0]    w5_sum;
    logic [42:0]    w5_rnd;
    logic [16:0]    w5_r;
    logic           w5_sat;
    logic [XW-1:0]  r5_y;
    logic           r5_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign w_oms = ONE_W - i_post.s;
    assign w_ds  = 62'(i_post.s) * 62'(w_oms);
    assign w_tsq = 62'(i_post.t) * 62'(i_post.t);
    assign w_ax  = 47'(i_post.side.a) * 47'(i_post.s);
    assign w_spv = (i_post.side.neg ? 36'd0 : 36'(i_post.side.a) << 19) + 36'(i_ln);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_post <= i_post;
            r1_ds   <= w_ds[MGW-1:0];
            r1_tt   <= (MGW'(1) << 60) - w_tsq[MGW-1:0];
            r1_ax   <= w_ax;
            r1_spv  <= w_spv;
        end
    end

    assign w2_pr = r1_ds + (MGW'(1) << 29);

    always_comb begin
        w2_mag = MGW'(r1_post.s);
        w2_sgn = 1'b0;
        w2_fr  = FR_30;
        unique case (r1_post.side.op) inside
            OP_SIG, OP_DSOFTP: begin
                w2_mag = MGW'(r1_post.s);
            end
            OP_DSIG: begin
                w2_mag = r1_ds;
                w2_fr  = FR_60;
            end
            OP_TANH: begin
                w2_mag = MGW'(r1_post.t);
                w2_sgn = r1_post.side.neg;
            end
            OP_DTANH: begin
                w2_mag = r1_tt;
                w2_fr  = FR_60;
            end
            OP_SOFTP: begin
                w2_mag = MGW'(r1_spv);
            end
            OP_SWISH: begin
                w2_mag = MGW'(r1_ax);
                w2_sgn = r1_post.side.neg;
                w2_fr  = FR_41;
            end
            OP_DSWISH: begin
                w2_fr = FR_41;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_post.side;
            r2_s    <= r1_post.s;
            r2_p    <= w2_pr[58:30];
            r2_mag  <= w2_mag;
            r2_sgn  <= w2_sgn;
            r2_fr   <= w2_fr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side <= r2_side;
            r3_s    <= r2_s;
            r3_xp   <= 45'(r2_side.a) * 45'(r2_p);
            r3_mag  <= r2_mag;
            r3_sgn  <= r2_sgn;
            r3_fr   <= r2_fr;
        end
    end

    // s + x*s*(1-s), sign of x on the product term
    assign w4_sh = 46'(r3_s) << 11;
    assign w4_xp = 46'(r3_xp);

    always_comb begin
        w4_mag = r3_mag;
        w4_sgn = r3_sgn;
        if (r3_side.op == OP_DSWISH) begin
            if (!r3_side.neg) begin
                w4_mag = MGW'(w4_sh + w4_xp);
                w4_sgn = 1'b0;
            end else if (w4_xp > w4_sh) begin
                w4_mag = MGW'(w4_xp - w4_sh);
                w4_sgn = 1'b1;
            end else begin
                w4_mag = MGW'(w4_sh - w4_xp);
                w4_sgn = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mag <= w4_mag;
            r4_sgn <= w4_sgn;
            r4_fr  <= r3_fr;
        end
    end

    always_comb begin
        case (r4_fr)
            FR_30: begin
                w5_sum = 62'(r4_mag) + (62'(1) << 18);
                w5_rnd = 43'(w5_sum >> 19);
            end
            FR_41: begin
                w5_sum = 62'(r4_mag) + (62'(1) << 29);
                w5_rnd = 43'(w5_sum >> 30);
            end
            default: begin
                w5_sum = 62'(r4_mag) + (62'(1) << 48);
                w5_rnd = 43'(w5_sum >> 49);
            end
        endcase
        if (!r4_sgn && w5_rnd > 43'd32767) begin
            w5_r   = 17'd32767;
            w5_sat = 1'b1;
        end else if (r4_sgn && w5_rnd > 43'd32768) begin
            w5_r   = 17'd32768;
            w5_sat = 1'b1;
        end else begin
            w5_r   = w5_rnd[16:0];
            w5_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_y   <= XW'(r4_sgn ? 17'd0 - w5_r : w5_r);
            r5_sat <= w5_sat;
        end
    end

    assign o_vld = r_vld[4];
    assign o_y   = r5_y;
    assign o_sat = r5_sat;

endmodule

`default_nettype wire

// ===== rtl/core/activation_function_unit_top.sv =====
// ----------------------------------------------------------------------------
// activation_function_unit_top
// Sigmoid, tanh, softplus, swish and their derivatives on Q4.11 values.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: tdata carries x (signed Q4.11), tuser carries the op code
//   (0 sigmoid, 1 sigmoid', 2 tanh, 3 tanh', 4 softplus, 5 softplus',
//   6 swish, 7 swish'). Output stream: tdata carries y (signed Q4.11),
//   tuser[0] flags a result clipped to the Q4.11 range.
//   Throughput: one beat per cycle while not held, any op mix, no state between beats.
//   Each beat passes the input register, the 14-term exp series, the
//   31-step divider, the 12-term atanh series and the output stages.
//   Back pressure: the whole pipeline holds while a result waits unaccepted;
//   s_axis_tready is low exactly then, nothing is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline; no beat is
//   presented until new input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module activation_function_unit_top
    import afu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [XW-1:0] i_s_axis_tdata,   // [15:0] x_value
    input  logic [2:0]    i_s_axis_tuser,   // [2:0] op
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [XW-1:0] o_m_axis_tdata,   // [15:0] y_value
    output logic [0:0]    o_m_axis_tuser    // [0] saturated
);

    logic             w_en;
    logic             r_in_vld;
    t_side            r_in_side;
    t_side            w_side;
    logic             w_exp_vld;
    t_side            w_exp_side;
    logic [1:0][30:0] w_e;
    logic             w_div_vld;
    t_post            w_div_post;
    logic [30:0]      w_z;
    logic             w_ln_vld;
    t_post            w_ln_post;
    logic [31:0]      w_ln;
    logic             w_sat;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_side.op  = t_op'(i_s_axis_tuser);
    assign w_side.neg = i_s_axis_tdata[XW-1];
    assign w_side.a   = i_s_axis_tdata[XW-1] ? AW'(17'h1_0000 - 17'(i_s_axis_tdata))
                                             : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_side <= w_side;
        end
    end

    afu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_side  (r_in_side),
        .o_vld   (w_exp_vld),
        .o_side  (w_exp_side),
        .o_e     (w_e)
    );

    afu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_exp_vld),
        .i_side  (w_exp_side),
        .i_e     (w_e),
        .o_vld   (w_div_vld),
        .o_post  (w_div_post),
        .o_z     (w_z)
    );

    afu_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_post  (w_div_post),
        .i_z     (w_z),
        .o_vld   (w_ln_vld),
        .o_post  (w_ln_post),
        .o_ln    (w_ln)
    );

    afu_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ln_vld),
        .i_post  (w_ln_post),
        .i_ln    (w_ln),
        .o_vld   (o_m_axis_tvalid),
        .o_y     (o_m_axis_tdata),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tuser = w_sat;

endmodule

`default_nettype wire

// ===== rtl/core/afu_checker.sv =====
// ----------------------------------------------------------------------------
// afu_checker
// Port-level checks on the activation function unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "activation_function_unit_top_assert.svh"

module afu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_ready,
    input logic        i_m_valid,
    input logic        i_m_ready,
    input logic [15:0] i_m_data,
    input logic [0:0]  i_m_user
);

    `AFU_ASSERT(a_out_hold, i_m_valid && !i_m_ready |=> i_m_valid && $stable(i_m_data) && $stable(i_m_user), "result beat changed while stalled")
    `AFU_ASSERT(a_sat_code, i_m_valid && i_m_user[0] |-> (i_m_data == 16'h7fff || i_m_data == 16'h8000), "saturated beat not at a range limit")
    `AFU_ASSERT(a_ready_empty, !i_m_valid |-> i_s_ready, "input stalled with empty output")
    `AFU_ASSERT(a_stall_in, i_m_valid && !i_m_ready |-> !i_s_ready, "input taken while pipeline held")

endmodule

bind activation_function_unit_top afu_checker u_afu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_ready (o_s_axis_tready),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata),
    .i_m_user  (o_m_axis_tuser)
);

`default_nettype wire
